// ===== rtl/paqd_pkg.sv =====
// Shared types and constants of the announcement admission controller.
package paqd_pkg;

    localparam int unsigned MODE_W     = 2;
    localparam int unsigned HANDLE_W   = 32;
    localparam int unsigned PRIO_W     = 8;
    localparam int unsigned SEQ_W      = 64;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned THRESH_W   = 7;
    localparam int unsigned LIMIT_W    = 4;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [MODE_W-1:0] MODE_SUBMIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DONE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BACKLOG   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd6;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLED   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT     = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd90;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd3;

    // One queued announcement.
    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // Command from the sequencer, shared by every queue cell.
    typedef struct packed {
        logic   shift;   // take the right neighbor's entry
        logic   load;    // the cell at the tail index takes new_entry
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ===== rtl/priority_announcement_queue_dedupe_core.sv =====
// Top level of the announcement admission controller with sequence dedupe.
// A new submit scans the seen-window entries one by one, each with a memory read and then a
// compare, before it is answered; an urgent submit then also purges the queued non-urgent entries.
// A zero sequence skips the scan and is not recorded in the seen window.
// One item at a time: the next item is accepted in the cycle after the result is taken.
// Reset clears all counts, the playing flag and the registers to 1, 90 and 3; the memories keep data.
module priority_announcement_queue_dedupe_core #(
    parameter int unsigned SEEN_DEPTH  = 256,
    parameter int unsigned QUEUE_DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [paqd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [paqd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mode[1:0]
    input  logic [paqd_pkg::MODE_W-1:0]   s_tuser,
    // text_handle[31:0], text_present[32], priority_req[40:33],
    // sequence_req[104:41], zero fill to 112
    input  logic [111:0]                  s_tdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    // status[2:0], stop_playback[3], purged_count[8:4], queue_count[13:9],
    // out_text_handle[45:14], out_priority[53:46], out_sequence[117:54], zero fill to 120
    output logic [119:0]                  m_tdata
);
    import paqd_pkg::*;

    localparam int unsigned SEEN_IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int unsigned SEEN_CNT_W = $clog2(SEEN_DEPTH + 1);
    localparam int unsigned Q_IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int unsigned Q_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_PURGE, S_FINISH, S_OUT
    } state_t;

    // Configuration registers.
    logic                enabled_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            thresh_reg  <= THRESH_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_ENABLED:   enabled_reg <= cfg_data[0];
                CFG_THRESHOLD: thresh_reg  <= cfg_data[THRESH_W-1:0];
                CFG_LIMIT:     limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Latched input item.
    logic [MODE_W-1:0] mode_reg;
    logic              present_reg;
    entry_t            item_reg;

    // The seen window lives in a single-port memory with registered read data.
    logic [SEQ_W-1:0]      seen_mem [SEEN_DEPTH];
    logic [SEQ_W-1:0]      seen_rd_reg;
    logic                  seen_we;
    logic [SEEN_IDX_W-1:0] seen_addr;
    logic [SEEN_CNT_W-1:0] seen_count_reg;
    logic [SEEN_IDX_W-1:0] seen_oldest_reg;
    logic [SEEN_CNT_W-1:0] scan_reg;

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_addr] <= item_reg.seq;
        end
        seen_rd_reg <= seen_mem[seen_addr];
    end

    // Ring position of the scan index or of the slot to write.
    logic [SEEN_CNT_W:0] ring_sum;
    logic [SEEN_CNT_W-1:0] ring_off;
    assign ring_off = seen_we ? ((seen_count_reg == SEEN_CNT_W'(SEEN_DEPTH)) ? '0
                                                                            : seen_count_reg)
                              : scan_reg;
    assign ring_sum = (SEEN_CNT_W+1)'(seen_oldest_reg) + (SEEN_CNT_W+1)'(ring_off);
    assign seen_addr = (ring_sum >= (SEEN_CNT_W+1)'(SEEN_DEPTH))
                     ? SEEN_IDX_W'(ring_sum - (SEEN_CNT_W+1)'(SEEN_DEPTH))
                     : SEEN_IDX_W'(ring_sum);

    // Queue: row of cells, head in cell zero.
    cell_ctrl_t          ctrl;
    entry_t              head;
    logic [Q_CNT_W-1:0]  qlen_reg;
    logic [Q_CNT_W-1:0]  rd_reg;     // purge read position
    logic [Q_CNT_W-1:0]  kept_reg;   // purge entries kept so far
    logic [COUNT_W-1:0]  purged_reg;
    logic [Q_CNT_W-1:0]  tail_cnt;

    paqd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .IDX_W(Q_IDX_W)) u_queue
    (
        .clk      (clk),
        .ctrl     (ctrl),
        .tail_idx (Q_IDX_W'(tail_cnt)),
        .head     (head)
    );

    state_t             state_reg;
    logic               playing_reg;
    logic [PRIO_W-1:0]  play_prio_reg;
    logic [STATUS_W-1:0] status_reg;
    logic               stop_reg;
    entry_t             out_entry_reg;

    // During a purge the unread entries sit in front and the kept ones follow them; each
    // shift moves both down by one, so a kept head goes in right after the kept ones.
    assign tail_cnt = (state_reg == S_PURGE) ? (qlen_reg - Q_CNT_W'(1) - rd_reg + kept_reg)
                                             : qlen_reg;

    logic urgent;
    assign urgent = item_reg.prio >= PRIO_W'(thresh_reg);

    // Purge rotates the whole queue once: a kept head goes back in behind the kept entries.
    logic purge_keep;
    assign purge_keep = head.prio >= PRIO_W'(thresh_reg);

    always_comb
    begin
        ctrl.shift     = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.new_entry = item_reg;
        seen_we        = 1'b0;
        unique case (state_reg)
            S_SCAN_RD:
            begin
                seen_we = (scan_reg == seen_count_reg) && (item_reg.seq != '0);
            end
            S_PURGE:
            begin
                if (rd_reg != qlen_reg)
                begin
                    ctrl.shift     = 1'b1;
                    ctrl.load      = purge_keep;
                    ctrl.new_entry = head;
                end
            end
            S_FINISH:
            begin
                if (mode_reg == MODE_POP)
                begin
                    ctrl.shift = qlen_reg != '0;
                end
                else if (mode_reg == MODE_SUBMIT && present_reg && enabled_reg
                         && !(!urgent && qlen_reg >= Q_CNT_W'(limit_reg))
                         && qlen_reg < Q_CNT_W'(QUEUE_DEPTH))
                begin
                    ctrl.load = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            seen_count_reg  <= '0;
            seen_oldest_reg <= '0;
            qlen_reg        <= '0;
            playing_reg     <= 1'b0;
            play_prio_reg   <= '0;
            scan_reg        <= '0;
            rd_reg          <= '0;
            kept_reg        <= '0;
            purged_reg      <= '0;
            status_reg      <= ST_DONE;
            stop_reg        <= 1'b0;
            out_entry_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        scan_reg   <= '0;
                        purged_reg <= '0;
                        stop_reg   <= 1'b0;
                        if (s_tuser == MODE_SUBMIT && s_tdata[32] && enabled_reg)
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    if (item_reg.seq == '0)
                    begin
                        state_reg <= urgent ? S_PURGE : S_FINISH;
                    end
                    else if (scan_reg == seen_count_reg)
                    begin
                        if (seen_count_reg == SEEN_CNT_W'(SEEN_DEPTH))
                        begin
                            seen_oldest_reg <= (seen_oldest_reg == SEEN_IDX_W'(SEEN_DEPTH - 1))
                                             ? '0 : seen_oldest_reg + 1'b1;
                        end
                        else
                        begin
                            seen_count_reg <= seen_count_reg + 1'b1;
                        end
                        state_reg <= urgent ? S_PURGE : S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CMP;
                    end
                    rd_reg   <= '0;
                    kept_reg <= '0;
                end
                S_SCAN_CMP:
                begin
                    if (seen_rd_reg == item_reg.seq)
                    begin
                        status_reg <= ST_DUPLICATE;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_PURGE:
                begin
                    if (rd_reg != qlen_reg)
                    begin
                        rd_reg <= rd_reg + 1'b1;
                        if (purge_keep)
                        begin
                            kept_reg <= kept_reg + 1'b1;
                        end
                        else
                        begin
                            purged_reg <= purged_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        qlen_reg  <= kept_reg;
                        stop_reg  <= playing_reg && (play_prio_reg < PRIO_W'(thresh_reg));
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_OUT;
                    unique case (mode_reg)
                        MODE_SUBMIT:
                        begin
                            if (!present_reg || !enabled_reg)
                            begin
                                status_reg <= ST_IGNORED;
                            end
                            else if (!urgent && qlen_reg >= Q_CNT_W'(limit_reg))
                            begin
                                status_reg <= ST_BACKLOG;
                            end
                            else if (qlen_reg >= Q_CNT_W'(QUEUE_DEPTH))
                            begin
                                status_reg <= ST_OVERFLOW;
                            end
                            else
                            begin
                                status_reg <= ST_QUEUED;
                                qlen_reg   <= qlen_reg + 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            if (qlen_reg != '0)
                            begin
                                status_reg    <= ST_POPPED;
                                out_entry_reg <= head;
                                qlen_reg      <= qlen_reg - 1'b1;
                                playing_reg   <= 1'b1;
                                play_prio_reg <= head.prio;
                            end
                            else
                            begin
                                status_reg <= ST_DONE;
                            end
                        end
                        MODE_DONE:
                        begin
                            status_reg    <= ST_DONE;
                            playing_reg   <= 1'b0;
                            play_prio_reg <= '0;
                        end
                        MODE_RESET:
                        begin
                            status_reg      <= ST_DONE;
                            stop_reg        <= playing_reg;
                            qlen_reg        <= '0;
                            seen_count_reg  <= '0;
                            seen_oldest_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload capture carries no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            mode_reg        <= s_tuser;
            item_reg.handle <= s_tdata[31:0];
            present_reg     <= s_tdata[32];
            item_reg.prio   <= s_tdata[40:33];
            item_reg.seq    <= s_tdata[104:41];
        end
    end

    entry_t out_shown;
    assign out_shown = (status_reg == ST_POPPED) ? out_entry_reg : '0;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = state_reg == S_OUT;
    assign m_tdata  = {2'b0, out_shown.seq, out_shown.prio, out_shown.handle,
                       COUNT_W'(qlen_reg), purged_reg, stop_reg, status_reg};

    // The queue never holds more entries than it has cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        qlen_reg <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("queue length beyond depth");

    // The seen window never counts past its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_count_reg <= SEEN_CNT_W'(SEEN_DEPTH))
        else $error("seen count beyond depth");

    // During a purge, the kept and purged entries together always equal the entries read.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PURGE |-> (COUNT_W'(kept_reg) + purged_reg) == COUNT_W'(rd_reg))
        else $error("purge bookkeeping mismatch");

    // A popped result always sets the playing flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status_reg == ST_POPPED |-> playing_reg)
        else $error("pop without playing");

endmodule

// ===== rtl/paqd_cell.sv =====
// Queue cell: holds an entry; a load at the tail wins over a shift from the right.
module paqd_cell
(
    input  logic                clk,
    input  paqd_pkg::cell_ctrl_t ctrl,
    input  logic                is_tail,
    input  paqd_pkg::entry_t    right_entry,
    output paqd_pkg::entry_t    entry
);
    import paqd_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && is_tail)
        begin
            entry_reg <= ctrl.new_entry;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/paqd_queue.sv =====
// Row of cells: shifts toward the head one place per cycle on ctrl.shift; loads at tail_idx.
module paqd_queue #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned IDX_W       = 4
)
(
    input  logic                 clk,
    input  paqd_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]     tail_idx,
    output paqd_pkg::entry_t     head
);
    import paqd_pkg::*;

    entry_t cell_out [QUEUE_DEPTH];

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        entry_t right;
        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid
            assign right = cell_out[g+1];
        end
        paqd_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .is_tail     (tail_idx == IDX_W'(g)),
            .right_entry (right),
            .entry       (cell_out[g])
        );
    end

    assign head = cell_out[0];

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the announcement admission controller with sequence dedupe.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import paqd_pkg::*;

    localparam int SEEN_N  = 256;
    localparam int QUEUE_N = 16;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PEND_N = 16;
    localparam int RECENT_N = 300;
    localparam int ROWS_N = 20;

    // One result item as seen on the master side.
    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  qcount;
        logic [COUNT_W-1:0]  purged;
        logic                stop;
        logic [STATUS_W-1:0] status;
    } outcome_t;

    // One row of the directed table; has_fixed marks rows whose result is typed in.
    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic                present;
        logic [PRIO_W-1:0]   prio;
        logic [SEQ_W-1:0]    seq;
        bit                  has_fixed;
        outcome_t            fixed;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [MODE_W-1:0] s_tuser;
    logic [111:0] s_tdata;
    logic m_tready;
    logic m_tvalid;
    logic [119:0] m_tdata;

    priority_announcement_queue_dedupe_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the block's registers and state.
    logic                enabled_q;
    logic [THRESH_W-1:0] threshold_q;
    logic [LIMIT_W-1:0]  limit_q;
    logic [SEQ_W-1:0]    seen_mem [SEEN_N];
    int                  seen_fill;
    int                  seen_head;
    entry_t              backlog [QUEUE_N];
    int                  backlog_len;
    logic                playing_q;
    logic [PRIO_W-1:0]   playing_prio_q;

    // Expected results waiting for the block, kept in a ring.
    outcome_t pend_buf [PEND_N];
    int  pend_wr;
    int  pend_rd;
    int  mismatches = 0;
    int  cycles = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  drive_on;
    logic [SEQ_W-1:0] recent_seqs [RECENT_N];
    int  recent_fill;
    int  recent_next;

    // Returns 1 when the sequence is new or zero, and records a new nonzero one.
    function automatic bit note_sequence(logic [SEQ_W-1:0] s);
        if (s == '0)
            return 1'b1;
        for (int i = 0; i < seen_fill; i++)
        begin
            if (seen_mem[(seen_head + i) % SEEN_N] == s)
                return 1'b0;
        end
        if (seen_fill < SEEN_N)
        begin
            seen_mem[(seen_head + seen_fill) % SEEN_N] = s;
            seen_fill++;
        end
        else
        begin
            seen_mem[seen_head] = s;
            seen_head = (seen_head + 1) % SEEN_N;
        end
        return 1'b1;
    endfunction

    // Advances the shadow state by one command and returns the result it must produce.
    function automatic outcome_t admit_command(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] h,
                                               logic present, logic [PRIO_W-1:0] p,
                                               logic [SEQ_W-1:0] s);
        outcome_t r;
        entry_t e;
        int w;
        bit urgent;
        r = '0;
        r.status = ST_DONE;
        w = 0;
        case (mode)
            MODE_SUBMIT:
            begin
                if (!present || !enabled_q)
                    r.status = ST_IGNORED;
                else if (!note_sequence(s))
                    r.status = ST_DUPLICATE;
                else
                begin
                    urgent = (p >= {1'b0, threshold_q});
                    if (urgent)
                    begin
                        // Urgent items purge every queued non-urgent entry, order kept.
                        for (int i = 0; i < backlog_len; i++)
                        begin
                            if (backlog[i].prio < {1'b0, threshold_q})
                                r.purged++;
                            else
                            begin
                                backlog[w] = backlog[i];
                                w++;
                            end
                        end
                        backlog_len = w;
                        if (playing_q && playing_prio_q < {1'b0, threshold_q})
                            r.stop = 1'b1;
                    end
                    if (!urgent && backlog_len >= limit_q)
                        r.status = ST_BACKLOG;
                    else if (backlog_len >= QUEUE_N)
                        r.status = ST_OVERFLOW;
                    else
                    begin
                        e.handle = h;
                        e.prio = p;
                        e.seq = s;
                        backlog[backlog_len] = e;
                        backlog_len++;
                        r.status = ST_QUEUED;
                    end
                end
            end
            MODE_POP:
            begin
                if (backlog_len > 0)
                begin
                    e = backlog[0];
                    for (int i = 1; i < backlog_len; i++)
                        backlog[i - 1] = backlog[i];
                    backlog_len--;
                    r.handle = e.handle;
                    r.prio = e.prio;
                    r.seq = e.seq;
                    playing_q = 1'b1;
                    playing_prio_q = e.prio;
                    r.status = ST_POPPED;
                end
            end
            MODE_DONE:
            begin
                playing_q = 1'b0;
                playing_prio_q = '0;
            end
            default:
            begin
                backlog_len = 0;
                seen_fill = 0;
                seen_head = 0;
                if (playing_q)
                    r.stop = 1'b1;
            end
        endcase
        r.qcount = COUNT_W'(backlog_len);
        return r;
    endfunction

    // Drops tvalid once between items; the next item raises it again.
    task automatic release_bus();
        if (drive_on)
        begin
            s_tvalid <= 1'b0;
            drive_on = 1'b0;
        end
    endtask

    // Drives one item and waits for its acceptance, with random idle cycles before it.
    task automatic send_command(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] h, logic present,
                                logic [PRIO_W-1:0] p, logic [SEQ_W-1:0] s, bit has_fixed,
                                outcome_t fixed);
        outcome_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            release_bus();
            @(posedge clk);
        end
        s_tuser <= mode;
        s_tdata <= {7'd0, s, p, present, h};
        s_tvalid <= 1'b1;
        drive_on = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = admit_command(mode, h, present, p, s);
        if (has_fixed && predicted != fixed)
            $display("table row disagrees with predictor: %h vs %h", fixed, predicted);
        pend_buf[pend_wr % PEND_N] = has_fixed ? fixed : predicted;
        pend_wr++;
    endtask

    task automatic wait_drained();
        release_bus();
        while (pend_wr != pend_rd)
            @(posedge clk);
    endtask

    // Registers change only with the block idle; the extra wait covers its last item.
    task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (SEEN_N + 2 * QUEUE_N + 8) @(posedge clk);
        cfg_addr <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLED:   enabled_q = val[0];
            CFG_THRESHOLD: threshold_q = val[THRESH_W-1:0];
            CFG_LIMIT:     limit_q = val[LIMIT_W-1:0];
            default:       ;
        endcase
    endtask

    // Mostly fresh sequences, some zero or recently used, so that duplicates and evictions both occur.
    function automatic logic [SEQ_W-1:0] pick_sequence();
        logic [SEQ_W-1:0] s;
        int k;
        k = $urandom_range(99);
        if (k < 8)
            s = '0;
        else if (k < 30 && recent_fill > 0)
            s = recent_seqs[$urandom_range(recent_fill - 1)];
        else
        begin
            s = {$urandom, $urandom};
            recent_seqs[recent_next] = s;
            recent_next = (recent_next + 1) % RECENT_N;
            if (recent_fill < RECENT_N)
                recent_fill++;
        end
        return s;
    endfunction

    task automatic send_random(int n);
        int k;
        logic [MODE_W-1:0] mode;
        logic [PRIO_W-1:0] p;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 62)
                mode = MODE_SUBMIT;
            else if (k < 86)
                mode = MODE_POP;
            else if (k < 98)
                mode = MODE_DONE;
            else
                mode = MODE_RESET;
            // Priorities cluster around the threshold, with full-range outliers.
            if ($urandom_range(3) == 0)
                p = PRIO_W'($urandom_range(255));
            else
                p = PRIO_W'(int'(threshold_q) + int'($urandom_range(20)) - 10);
            send_command(mode, $urandom, $urandom_range(15) != 0, p, pick_sequence(),
                         1'b0, '0);
        end
    endtask

    // Result side: random stalls, and every accepted item is compared with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[117:0];
                if (pend_wr == pend_rd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %h", got);
                end
                else
                begin
                    want = pend_buf[pend_rd % PEND_N];
                    pend_rd++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: status %0d/%0d stop %0d/%0d purged %0d/%0d",
                                     want.status, got.status, want.stop, got.stop,
                                     want.purged, got.purged);
                        if (mismatches <= 10)
                            $display("  count %0d/%0d handle %h/%h prio %0d/%0d seq %h/%h",
                                     want.qcount, got.qcount, want.handle, got.handle,
                                     want.prio, got.prio, want.seq, got.seq);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    row_t directed [ROWS_N];

    function automatic row_t mk(logic [MODE_W-1:0] m, logic [HANDLE_W-1:0] h, logic pr,
                                logic [PRIO_W-1:0] p, logic [SEQ_W-1:0] s);
        row_t r;
        r.mode = m;
        r.handle = h;
        r.present = pr;
        r.prio = p;
        r.seq = s;
        r.has_fixed = 1'b0;
        r.fixed = '0;
        return r;
    endfunction

    function automatic row_t mkf(row_t r, logic [STATUS_W-1:0] st, logic stp,
                                 logic [COUNT_W-1:0] qc);
        r.has_fixed = 1'b1;
        r.fixed.status = st;
        r.fixed.stop = stp;
        r.fixed.qcount = qc;
        return r;
    endfunction

    initial
    begin
        row_t r;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        drive_on = 1'b0;
        pend_wr = 0;
        pend_rd = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        enabled_q = 1'b1;
        threshold_q = THRESH_RESET;
        limit_q = LIMIT_RESET;
        seen_fill = 0;
        seen_head = 0;
        backlog_len = 0;
        recent_fill = 0;
        recent_next = 0;
        playing_q = 1'b0;
        playing_prio_q = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty pop, ignored, duplicate, backlog, purge, stop, done, reset.
        directed[0]  = mkf(mk(MODE_POP, '1, 1'b1, 8'hff, '1), ST_DONE, 1'b0, 5'd0);
        directed[1]  = mkf(mk(MODE_DONE, '0, 1'b0, 8'd0, '0), ST_DONE, 1'b0, 5'd0);
        directed[2]  = mkf(mk(MODE_SUBMIT, '1, 1'b0, 8'hff, '1), ST_IGNORED, 1'b0, 5'd0);
        directed[3]  = mkf(mk(MODE_SUBMIT, 32'h1, 1'b1, 8'd0, '1), ST_QUEUED, 1'b0, 5'd1);
        directed[4]  = mkf(mk(MODE_SUBMIT, 32'h2, 1'b1, 8'd10, '1), ST_DUPLICATE, 1'b0, 5'd1);
        directed[5]  = mkf(mk(MODE_SUBMIT, '1, 1'b1, 8'd89, '0), ST_QUEUED, 1'b0, 5'd2);
        directed[6]  = mkf(mk(MODE_SUBMIT, 32'h3, 1'b1, 8'd5, '0), ST_QUEUED, 1'b0, 5'd3);
        directed[7]  = mkf(mk(MODE_SUBMIT, 32'h4, 1'b1, 8'd5, 64'h4), ST_BACKLOG, 1'b0, 5'd3);
        directed[8]  = mkf(mk(MODE_SUBMIT, 32'h5, 1'b1, 8'd5, 64'h4), ST_DUPLICATE, 1'b0, 5'd3);
        directed[9]  = mk(MODE_POP, '0, 1'b0, 8'd0, '0);
        directed[10] = mk(MODE_SUBMIT, 32'h6, 1'b1, 8'd90, 64'h6);
        directed[11] = mk(MODE_SUBMIT, 32'h7, 1'b1, 8'hff, 64'h8000_0000_0000_0000);
        directed[12] = mk(MODE_POP, '0, 1'b1, 8'd0, '0);
        directed[13] = mk(MODE_SUBMIT, 32'h8, 1'b1, 8'd1, '0);
        directed[14] = mk(MODE_POP, '0, 1'b0, 8'd0, '0);
        directed[15] = mk(MODE_SUBMIT, 32'h9, 1'b1, 8'd200, '0);
        directed[16] = mkf(mk(MODE_RESET, '0, 1'b0, 8'd0, '0), ST_DONE, 1'b1, 5'd0);
        directed[17] = mkf(mk(MODE_SUBMIT, 32'ha, 1'b1, 8'd0, '1), ST_QUEUED, 1'b0, 5'd1);
        directed[18] = mkf(mk(MODE_DONE, '0, 1'b0, 8'd0, '0), ST_DONE, 1'b0, 5'd1);
        directed[19] = mkf(mk(MODE_RESET, '1, 1'b1, 8'hff, '1), ST_DONE, 1'b0, 5'd0);
        foreach (directed[i])
        begin
            r = directed[i];
            send_command(r.mode, r.handle, r.present, r.prio, r.seq, r.has_fixed, r.fixed);
        end

        // Pause until everything has drained, then random phases under varied settings.
        wait_drained();
        write_register(CFG_ENABLED, 7'd0);
        send_command(MODE_SUBMIT, 32'h11, 1'b1, 8'd200, 64'h11, 1'b0, '0);
        write_register(CFG_ENABLED, 7'd1);
        write_register(CFG_THRESHOLD, 7'd100);
        write_register(CFG_LIMIT, 7'd12);
        send_random(300);
        send_idle_pct = 61;
        write_register(CFG_THRESHOLD, 7'd0);
        write_register(CFG_LIMIT, 7'd1);
        send_random(150);
        write_register(CFG_THRESHOLD, 7'd50);
        write_register(CFG_LIMIT, 7'd7);
        send_idle_pct = 0;
        recv_stall_pct = 61;
        send_random(450);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        write_register(CFG_LIMIT, 7'd0);
        send_random(150);
        write_register(CFG_THRESHOLD, 7'd90);
        write_register(CFG_LIMIT, 7'd3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(750);

        wait_drained();
        repeat (SEEN_N + 2 * QUEUE_N + 8) @(posedge clk);
        if (mismatches == 0 && pend_wr == pend_rd)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
